@@ rtl/bpa_pkg.sv @@
// Shared types and constants for the bump page allocator region pick unit.
package bpa_pkg;

    // Address arithmetic width; all sums wrap at this width
    localparam int AddrBits = 64;
    localparam int PgShift  = 12;
    // Width of the pages_used result field
    localparam int PagesW   = 53;
    // Pages counter width: AddrBits - 12 bits, capped at PagesW
    localparam int PageCntW = ((AddrBits - PgShift) < PagesW) ? (AddrBits - PgShift) : PagesW;

    // Port field widths
    localparam int TypeW    = 8;
    localparam int FieldW   = 64;
    localparam int SDataW   = 136;  // type + base + length, already whole bytes
    localparam int MFieldW  = 183;  // page_addr + pages_used + region_base + status
    localparam int MDataW   = 184;

    typedef logic [AddrBits-1:0] addr_t;
    typedef logic [PageCntW-1:0] page_cnt_t;

    localparam addr_t PgSize = addr_t'(4096);
    localparam addr_t PgMask = addr_t'(4095);
    // 4 GiB, one bit wider than the widest address so the compare never wraps
    localparam logic [FieldW:0] FourGib = 65'h1_0000_0000;

    typedef enum logic [1:0] {
        FUNC_ENTRY = 2'd0,
        FUNC_INIT  = 2'd1,
        FUNC_ALLOC = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_REGION = 2'd1,
        ST_NO_PAGES  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_FORCED_MODE  = 2'd0,
        CFG_FORCED_BASE  = 2'd1,
        CFG_FORCED_PAGES = 2'd2,
        CFG_USABLE_TYPE  = 2'd3
    } cfg_idx_t;

    // Page-trimmed map entry, handed from the trim logic to the input register
    typedef struct packed {
        logic  vld;        // usable type and nonempty after trimming
        logic  low;        // trimmed end at or below 4 GiB
        addr_t start_addr;
        addr_t end_addr;
        addr_t size;
    } entry_trim_t;

endpackage

@@ rtl/bpa_entry_trim.sv @@
// Page trimming of one memory map entry: round base up, round end down.
module bpa_entry_trim
(
    input  logic [bpa_pkg::TypeW-1:0]  entry_type,
    input  logic [bpa_pkg::FieldW-1:0] entry_base,
    input  logic [bpa_pkg::FieldW-1:0] entry_length,
    input  logic [bpa_pkg::TypeW-1:0]  usable_type,
    output bpa_pkg::entry_trim_t       trim
);

    bpa_pkg::addr_t base;
    bpa_pkg::addr_t len;
    bpa_pkg::addr_t start_a;
    bpa_pkg::addr_t end_a;

    // Both sums wrap at the address width
    always_comb
    begin
        base    = bpa_pkg::addr_t'(entry_base);
        len     = bpa_pkg::addr_t'(entry_length);
        start_a = (base + bpa_pkg::PgMask) & ~bpa_pkg::PgMask;
        end_a   = (base + len) & ~bpa_pkg::PgMask;
    end

    // Entry counts only when its type is usable and something is left after trimming
    always_comb
    begin
        trim.vld        = (entry_type == usable_type) && (end_a > start_a);
        trim.low        = ((bpa_pkg::FieldW + 1)'(end_a)) <= bpa_pkg::FourGib;
        trim.start_addr = start_a;
        trim.end_addr   = end_a;
        trim.size       = end_a - start_a;
    end

endmodule

@@ rtl/bump_page_allocator_region_pick_unit.sv @@
// Top level: memory map region pick and bump page allocator, one request per cycle while m_tready holds.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  s_      | s_tvalid / s_tready | s_tuser: func; s_tdata: type, base, length
//  m_      | m_tvalid / m_tready | m_tdata: page_addr, pages_used, region_base,
//          |                     |          status
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// Each request passes an input register and a result register, one request per
// cycle sustained while m_tready holds. The allocator state updates as a request
// moves into the result register, so the next request sees it at once.
// Reset clears the configuration, the trackers, the region and the cursor.
// A stalled result holds the result register; the input register keeps
// accepting until it also holds a request.
module bump_page_allocator_region_pick_unit
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [7:0] entry_type, [71:8] entry_base, [135:72] entry_length
    input  logic [bpa_pkg::SDataW-1:0]  s_tdata,
    // [1:0] func
    input  logic [1:0]                  s_tuser,

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [63:0] page_addr, [116:64] pages_used, [180:117] region_base,
    // [182:181] status, [183] zero
    output logic [bpa_pkg::MDataW-1:0]  m_tdata,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [bpa_pkg::FieldW-1:0]  cfg_data
);

    // Configuration registers
    logic                          forced_mode_reg;
    logic [bpa_pkg::FieldW-1:0]    forced_base_reg;
    logic [bpa_pkg::PagesW-1:0]    forced_pages_reg;
    logic [bpa_pkg::TypeW-1:0]     usable_type_reg;

    // Input register
    logic                          in_vld_reg;
    bpa_pkg::func_t                in_func_reg;
    bpa_pkg::entry_trim_t          in_trim_reg;
    bpa_pkg::entry_trim_t          trim;

    // Allocator state
    bpa_pkg::addr_t                low_base_reg, low_base_next;
    bpa_pkg::addr_t                low_end_reg, low_end_next;
    bpa_pkg::addr_t                low_size_reg, low_size_next;
    bpa_pkg::addr_t                any_base_reg, any_base_next;
    bpa_pkg::addr_t                any_end_reg, any_end_next;
    bpa_pkg::addr_t                any_size_reg, any_size_next;
    bpa_pkg::addr_t                region_start_reg, region_start_next;
    bpa_pkg::addr_t                region_limit_reg, region_limit_next;
    bpa_pkg::addr_t                cursor_reg, cursor_next;
    bpa_pkg::page_cnt_t            pages_reg, pages_next;

    // Result register
    logic                          out_vld_reg;
    bpa_pkg::addr_t                out_addr_reg, out_addr_next;
    bpa_pkg::status_t              out_status_reg, out_status_next;
    bpa_pkg::page_cnt_t            out_pages_reg;
    bpa_pkg::addr_t                out_base_reg;

    // Handshake
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    // Working values
    bpa_pkg::addr_t                cand_base;
    bpa_pkg::addr_t                cand_limit;
    logic                          cand_bad;
    bpa_pkg::addr_t                alloc_next;

    assign out_free  = !out_vld_reg || m_tready;
    assign advance   = in_vld_reg && out_free;
    assign s_tready  = !in_vld_reg || out_free;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forced_mode_reg  <= 1'b0;
            forced_base_reg  <= '0;
            forced_pages_reg <= '0;
            usable_type_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bpa_pkg::cfg_idx_t'(cfg_index))
                bpa_pkg::CFG_FORCED_MODE:  forced_mode_reg  <= cfg_data[0];
                bpa_pkg::CFG_FORCED_BASE:  forced_base_reg  <= cfg_data;
                bpa_pkg::CFG_FORCED_PAGES: forced_pages_reg <= cfg_data[bpa_pkg::PagesW-1:0];
                bpa_pkg::CFG_USABLE_TYPE:  usable_type_reg  <= cfg_data[bpa_pkg::TypeW-1:0];
                default: ;
            endcase
        end
    end

    // Entry trimming ahead of the input register
    bpa_entry_trim u_trim
    (
        .entry_type   (s_tdata[7:0]),
        .entry_base   (s_tdata[71:8]),
        .entry_length (s_tdata[135:72]),
        .usable_type  (usable_type_reg),
        .trim         (trim)
    );

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= bpa_pkg::func_t'(s_tuser);
            in_trim_reg <= trim;
        end
    end

    // Init candidate: forced region, else low tracker, else any tracker
    always_comb
    begin
        if (forced_mode_reg)
        begin
            cand_base  = bpa_pkg::addr_t'(forced_base_reg);
            cand_limit = cand_base + bpa_pkg::addr_t'({forced_pages_reg, 12'b0});
        end
        else if (low_size_reg != '0)
        begin
            cand_base  = low_base_reg;
            cand_limit = low_end_reg;
        end
        else
        begin
            cand_base  = any_base_reg;
            cand_limit = any_end_reg;
        end
        cand_bad = (cand_base == '0) || (cand_limit <= cand_base)
                   || ((cand_base & bpa_pkg::PgMask) != '0);
    end

    assign alloc_next = cursor_reg + bpa_pkg::PgSize;

    // Request execution as it moves into the result register
    always_comb
    begin
        low_base_next     = low_base_reg;
        low_end_next      = low_end_reg;
        low_size_next     = low_size_reg;
        any_base_next     = any_base_reg;
        any_end_next      = any_end_reg;
        any_size_next     = any_size_reg;
        region_start_next = region_start_reg;
        region_limit_next = region_limit_reg;
        cursor_next       = cursor_reg;
        pages_next        = pages_reg;
        out_addr_next     = '0;
        out_status_next   = bpa_pkg::ST_OK;
        case (in_func_reg)
            bpa_pkg::FUNC_ENTRY:
            begin
                if (in_trim_reg.vld && in_trim_reg.low && (in_trim_reg.size > low_size_reg))
                begin
                    low_base_next = in_trim_reg.start_addr;
                    low_end_next  = in_trim_reg.end_addr;
                    low_size_next = in_trim_reg.size;
                end
                if (in_trim_reg.vld && (in_trim_reg.size > any_size_reg))
                begin
                    any_base_next = in_trim_reg.start_addr;
                    any_end_next  = in_trim_reg.end_addr;
                    any_size_next = in_trim_reg.size;
                end
            end
            bpa_pkg::FUNC_INIT:
            begin
                low_base_next = '0;
                low_end_next  = '0;
                low_size_next = '0;
                any_base_next = '0;
                any_end_next  = '0;
                any_size_next = '0;
                if (cand_bad)
                begin
                    out_status_next = bpa_pkg::ST_NO_REGION;
                end
                else
                begin
                    region_start_next = cand_base;
                    region_limit_next = cand_limit;
                    cursor_next       = cand_base;
                    pages_next        = '0;
                end
            end
            bpa_pkg::FUNC_ALLOC:
            begin
                if (alloc_next > region_limit_reg)
                begin
                    out_status_next = bpa_pkg::ST_NO_PAGES;
                end
                else
                begin
                    out_addr_next = cursor_reg;
                    cursor_next   = alloc_next;
                    pages_next    = pages_reg + bpa_pkg::page_cnt_t'(1);
                end
            end
            default: ;
        endcase
    end

    // Allocator state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_base_reg     <= '0;
            low_end_reg      <= '0;
            low_size_reg     <= '0;
            any_base_reg     <= '0;
            any_end_reg      <= '0;
            any_size_reg     <= '0;
            region_start_reg <= '0;
            region_limit_reg <= '0;
            cursor_reg       <= '0;
            pages_reg        <= '0;
        end
        else if (advance)
        begin
            low_base_reg     <= low_base_next;
            low_end_reg      <= low_end_next;
            low_size_reg     <= low_size_next;
            any_base_reg     <= any_base_next;
            any_end_reg      <= any_end_next;
            any_size_reg     <= any_size_next;
            region_start_reg <= region_start_next;
            region_limit_reg <= region_limit_next;
            cursor_reg       <= cursor_next;
            pages_reg        <= pages_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Result register payload, taken after this request's update
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
            out_pages_reg  <= pages_next;
            out_base_reg   <= region_start_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0,
                       out_status_reg,
                       bpa_pkg::FieldW'(out_base_reg),
                       bpa_pkg::PagesW'(out_pages_reg),
                       bpa_pkg::FieldW'(out_addr_reg)};

    // The low tracker is a subset of the any tracker, so it is never larger
    a_low_not_above_any: assert property (@(posedge clk) disable iff (!rst_n)
        low_size_reg <= any_size_reg)
        else $error("low tracker size exceeds overall tracker size");

    // Region base and cursor stay page aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ((region_start_reg & bpa_pkg::PgMask) == '0) && ((cursor_reg & bpa_pkg::PgMask) == '0))
        else $error("region base or cursor not page aligned");

    // Every init clears both trackers
    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == bpa_pkg::FUNC_INIT)
        |=> (low_size_reg == '0) && (any_size_reg == '0))
        else $error("trackers not cleared by init");

    // A successful allocate moves cursor and page count by exactly one page
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == bpa_pkg::FUNC_ALLOC) && (alloc_next <= region_limit_reg)
        |=> (cursor_reg == $past(cursor_reg) + bpa_pkg::PgSize)
            && (pages_reg == $past(pages_reg) + bpa_pkg::page_cnt_t'(1)))
        else $error("allocate did not advance cursor by one page");

    // A failed allocate leaves the cursor alone
    a_alloc_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == bpa_pkg::FUNC_ALLOC) && (alloc_next > region_limit_reg)
        |=> $stable(cursor_reg) && $stable(pages_reg))
        else $error("failed allocate changed the cursor");

endmodule
